FILE: hdl/per_sensor_running_statistics_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef PER_SENSOR_RUNNING_STATISTICS_UNIT_ASSERT_SVH
`define PER_SENSOR_RUNNING_STATISTICS_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define PSRS_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PSRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/psrs_pkg.sv
package psrs_pkg;

  localparam int SENSOR_SLOTS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int ID_BITS       = 4;
  localparam int VALUE_BITS    = 24;
  localparam int COUNT_OUT_BITS = 16;
  localparam int SQSUM_BITS    = 64;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_t;

endpackage

FILE: hdl/psrs_in_if.sv
interface psrs_in_if #(
  parameter int SAMPLE_BITS = psrs_pkg::SAMPLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  psrs_pkg::cmd_t                 command;
  logic [psrs_pkg::ID_BITS-1:0]   sensor_id;
  logic signed [SAMPLE_BITS-1:0]  sample;

  modport source (output valid, command, sensor_id, sample, input ready);
  modport sink   (input valid, command, sensor_id, sample, output ready);
endinterface

FILE: hdl/psrs_out_if.sv
interface psrs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic [psrs_pkg::COUNT_OUT_BITS-1:0]   sample_count;
  logic signed [psrs_pkg::VALUE_BITS-1:0] mean_value;
  logic signed [psrs_pkg::VALUE_BITS-1:0] min_value;
  logic signed [psrs_pkg::VALUE_BITS-1:0] max_value;
  logic [psrs_pkg::VALUE_BITS-1:0]       std_dev;

  modport source (output valid, found, sample_count, mean_value, min_value, max_value,
                  std_dev, input ready);
  modport sink   (input valid, found, sample_count, mean_value, min_value, max_value,
                  std_dev, output ready);
endinterface

FILE: hdl/psrs_ram.sv
module psrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/per_sensor_running_statistics_unit.sv
// Per-sensor running statistics. Each sensor slot keeps a count, a sum, a sum of squares,
// a minimum and a maximum of signed Q15.8 samples in one RAM word; per-slot valid flops
// make every slot read as empty right after reset, so there is no clearing pass. An add
// word (command 0) updates its slot and returns nothing; it is dropped when the slot count
// is all ones or the id is not below SENSOR_SLOTS. A report word (command 1) returns one
// result: found, count, mean (truncated toward zero), min, max and the population standard
// deviation floor(isqrt(n*sumsq - sum^2) / n), saturated to 24 bits. One word is worked on
// at a time and in_ready is high only while the block is idle; a finished result waits in
// the output register, so the next word can be taken before it is drained. Products,
// quotients and the square root are bit-serial, one result bit per cycle through shift
// registers. An add reads the slot, squares the sample serially and writes it back; a
// dropped add returns to idle after the read. A report runs the serial divider (mean),
// the multiplier twice (n*sumsq, then sum^2), the difference, the square root unit of
// R bits (half of the wider of COUNT_BITS + 64 and 2*S, S = SAMPLE_BITS + COUNT_BITS,
// rounded up) and the divider again; an empty slot goes from the read to the output.
module per_sensor_running_statistics_unit #(
  parameter int SENSOR_SLOTS = psrs_pkg::SENSOR_SLOTS_DEF,
  parameter int COUNT_BITS   = psrs_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS  = psrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  psrs_in_if.sink    in_bus,
  psrs_out_if.source out_bus
);

  localparam int VB         = psrs_pkg::VALUE_BITS;
  localparam int CB_OUT     = psrs_pkg::COUNT_OUT_BITS;
  localparam int SQ_BITS    = psrs_pkg::SQSUM_BITS;
  localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_BITS  = COUNT_BITS + SQ_BITS;
  localparam int SSQ_BITS   = 2 * SUM_BITS;
  localparam int VAR_RAW    = (PROD_BITS > SSQ_BITS) ? PROD_BITS : SSQ_BITS;
  localparam int ROOT_BITS  = (VAR_RAW + 1) / 2;
  localparam int VAR_BITS   = 2 * ROOT_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int DIV_BITS   = (SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS;
  localparam int MUL_BITS   = SUM_BITS;
  localparam int ITER_BITS  = $clog2(DIV_BITS);
  localparam int IDX_BITS   = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam int ID_EXT_BITS = (IDX_BITS > psrs_pkg::ID_BITS) ? IDX_BITS : psrs_pkg::ID_BITS;
  localparam int SX_BITS    = (SAMPLE_BITS > VB) ? SAMPLE_BITS : VB;
  localparam int NX_BITS    = (COUNT_BITS > CB_OUT) ? COUNT_BITS : CB_OUT;
  localparam int ENTRY_BITS = COUNT_BITS + SUM_BITS + SQ_BITS + 2 * SAMPLE_BITS;
  localparam int E_MAX_LO   = 0;
  localparam int E_MIN_LO   = SAMPLE_BITS;
  localparam int E_SQ_LO    = 2 * SAMPLE_BITS;
  localparam int E_SUM_LO   = E_SQ_LO + SQ_BITS;
  localparam int E_CNT_LO   = E_SUM_LO + SUM_BITS;

  localparam logic [ITER_BITS-1:0] CNT_SQR  = ITER_BITS'(SAMPLE_BITS - 1);
  localparam logic [ITER_BITS-1:0] CNT_PMUL = ITER_BITS'(COUNT_BITS - 1);
  localparam logic [ITER_BITS-1:0] CNT_QMUL = ITER_BITS'(SUM_BITS - 1);
  localparam logic [ITER_BITS-1:0] CNT_ROOT = ITER_BITS'(ROOT_BITS - 1);
  localparam logic [ITER_BITS-1:0] CNT_DIV  = ITER_BITS'(DIV_BITS - 1);

  localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_READ  = 11'b000_0000_0010,
    S_SQR   = 11'b000_0000_0100,
    S_WRITE = 11'b000_0000_1000,
    S_MEAN  = 11'b000_0001_0000,
    S_PMUL  = 11'b000_0010_0000,
    S_QMUL  = 11'b000_0100_0000,
    S_DIFF  = 11'b000_1000_0000,
    S_ROOT  = 11'b001_0000_0000,
    S_SDIV  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ITER_BITS-1:0]          cnt_r, cnt_nxt;
  psrs_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [IDX_BITS-1:0]           addr_r, addr_nxt;
  logic                          id_ok_r, id_ok_nxt;
  logic signed [SAMPLE_BITS-1:0] samp_r, samp_nxt;
  logic [COUNT_BITS-1:0]         n_r, n_nxt;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [SUM_BITS-1:0]           smag_r, smag_nxt;
  logic                          neg_r, neg_nxt;
  logic                          found_r, found_nxt;
  logic [VAR_BITS-1:0]           mcand_r, mcand_nxt;
  logic [MUL_BITS-1:0]           mplier_r, mplier_nxt;
  logic [VAR_BITS-1:0]           acc_r, acc_nxt;
  logic [VAR_BITS-1:0]           p_r, p_nxt;
  logic [DIV_BITS-1:0]           dq_r, dq_nxt;
  logic [COUNT_BITS-1:0]         drem_r, drem_nxt;
  logic [VAR_BITS-1:0]           rad_r, rad_nxt;
  logic [REM_BITS-1:0]           rrem_r, rrem_nxt;
  logic [ROOT_BITS-1:0]          root_r, root_nxt;
  logic [VB-1:0]                 mean_r, mean_nxt;
  logic [VB-1:0]                 sd_r, sd_nxt;
  logic [SENSOR_SLOTS-1:0]       valid_r, valid_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [CB_OUT-1:0]             out_count_r, out_count_nxt;
  logic [VB-1:0]                 out_mean_r, out_mean_nxt;
  logic [VB-1:0]                 out_min_r, out_min_nxt;
  logic [VB-1:0]                 out_max_r, out_max_nxt;
  logic [VB-1:0]                 out_sd_r, out_sd_nxt;

  logic                          in_fire;
  logic [ID_EXT_BITS-1:0]        id_ext;
  logic [IDX_BITS-1:0]           in_addr;
  logic                          in_id_ok;
  logic                          ram_we;
  logic [ENTRY_BITS-1:0]         ram_wdata;
  logic [ENTRY_BITS-1:0]         ram_rdata;

  logic                          ent_valid;
  logic [COUNT_BITS-1:0]         ent_cnt;
  logic signed [SUM_BITS-1:0]    ent_sum;
  logic [SQ_BITS-1:0]            ent_sq;
  logic signed [SAMPLE_BITS-1:0] ent_min;
  logic signed [SAMPLE_BITS-1:0] ent_max;
  logic [SUM_BITS-1:0]           ent_smag;
  logic [SAMPLE_BITS-1:0]        samp_mag;

  logic [VAR_BITS-1:0]           mul_add;
  logic [COUNT_BITS:0]           div_trial;
  logic [COUNT_BITS:0]           div_diff;
  logic                          div_ge;
  logic [COUNT_BITS-1:0]         div_rem;
  logic [DIV_BITS-1:0]           div_q;
  logic [REM_BITS-1:0]           root_sh;
  logic [REM_BITS-1:0]           root_trial;
  logic                          root_ge;
  logic [ROOT_BITS-1:0]          root_q;
  logic [NX_BITS-1:0]            n_x;
  logic signed [SX_BITS-1:0]     min_x;
  logic signed [SX_BITS-1:0]     max_x;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign id_ext       = ID_EXT_BITS'(in_bus.sensor_id);
  assign in_addr      = id_ext[IDX_BITS-1:0];
  assign in_id_ok     = (32'(in_bus.sensor_id) < 32'(SENSOR_SLOTS));

  assign ram_we    = (state_r == S_WRITE);
  assign ram_wdata = {n_r, sum_r, acc_r[SQ_BITS-1:0], min_r, max_r};

  psrs_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SENSOR_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (ram_wdata),
    .rd_addr (in_addr),
    .rd_data (ram_rdata)
  );

  // a slot not written since reset reads as the cleared entry
  assign ent_valid = valid_r[addr_r];
  assign ent_cnt   = ent_valid ? ram_rdata[E_CNT_LO +: COUNT_BITS] : '0;
  assign ent_sum   = ent_valid ? ram_rdata[E_SUM_LO +: SUM_BITS] : '0;
  assign ent_sq    = ent_valid ? ram_rdata[E_SQ_LO +: SQ_BITS] : '0;
  assign ent_min   = ent_valid ? ram_rdata[E_MIN_LO +: SAMPLE_BITS] : MIN_INIT;
  assign ent_max   = ent_valid ? ram_rdata[E_MAX_LO +: SAMPLE_BITS] : MAX_INIT;
  assign ent_smag  = ent_sum[SUM_BITS-1] ? $unsigned(-ent_sum) : $unsigned(ent_sum);
  assign samp_mag  = samp_r[SAMPLE_BITS-1] ? $unsigned(-samp_r) : $unsigned(samp_r);

  // shift-add multiplier, one multiplier bit per cycle
  assign mul_add = acc_r + (mplier_r[0] ? mcand_r : '0);

  // restoring divider by the count, one quotient bit per cycle
  assign div_trial = {drem_r, dq_r[DIV_BITS-1]};
  assign div_ge    = (div_trial >= {1'b0, n_r});
  assign div_diff  = div_trial - {1'b0, n_r};
  assign div_rem   = div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
  assign div_q     = {dq_r[DIV_BITS-2:0], div_ge};

  // digit-by-digit square root, two radicand bits per cycle
  assign root_sh    = {rrem_r[REM_BITS-3:0], rad_r[VAR_BITS-1 -: 2]};
  assign root_trial = {root_r, 2'b01};
  assign root_ge    = (root_sh >= root_trial);
  assign root_q     = {root_r[ROOT_BITS-2:0], root_ge};

  assign n_x   = NX_BITS'(n_r);
  assign min_x = SX_BITS'(min_r);
  assign max_x = SX_BITS'(max_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    id_ok_nxt     = id_ok_r;
    samp_nxt      = samp_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    smag_nxt      = smag_r;
    neg_nxt       = neg_r;
    found_nxt     = found_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    rad_nxt       = rad_r;
    rrem_nxt      = rrem_r;
    root_nxt      = root_r;
    mean_nxt      = mean_r;
    sd_nxt        = sd_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    out_mean_nxt  = out_mean_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_sd_nxt    = out_sd_r;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_bus.command;
          addr_nxt  = in_addr;
          id_ok_nxt = in_id_ok;
          samp_nxt  = in_bus.sample;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (cmd_r == psrs_pkg::CMD_ADD) begin
          if (!id_ok_r || (&ent_cnt)) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt      = ent_cnt + 1'b1;
            sum_nxt    = ent_sum + SUM_BITS'(samp_r);
            min_nxt    = (samp_r < ent_min) ? samp_r : ent_min;
            max_nxt    = (samp_r > ent_max) ? samp_r : ent_max;
            acc_nxt    = VAR_BITS'(ent_sq);
            mcand_nxt  = VAR_BITS'(samp_mag);
            mplier_nxt = MUL_BITS'(samp_mag);
            cnt_nxt    = CNT_SQR;
            state_nxt  = S_SQR;
          end
        end else begin
          if (!id_ok_r || (ent_cnt == '0)) begin
            found_nxt = 1'b0;
            state_nxt = S_OUT;
          end else begin
            found_nxt  = 1'b1;
            n_nxt      = ent_cnt;
            min_nxt    = ent_min;
            max_nxt    = ent_max;
            smag_nxt   = ent_smag;
            neg_nxt    = ent_sum[SUM_BITS-1];
            dq_nxt     = DIV_BITS'(ent_smag);
            drem_nxt   = '0;
            // n * sumsq operands wait in the multiplier during the mean division
            acc_nxt    = '0;
            mcand_nxt  = VAR_BITS'(ent_sq);
            mplier_nxt = MUL_BITS'(ent_cnt);
            cnt_nxt    = CNT_DIV;
            state_nxt  = S_MEAN;
          end
        end
      end
      S_SQR: begin
        acc_nxt    = mul_add;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        valid_nxt[addr_r] = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_MEAN: begin
        dq_nxt   = div_q;
        drem_nxt = div_rem;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          mean_nxt  = neg_r ? -div_q[VB-1:0] : div_q[VB-1:0];
          cnt_nxt   = CNT_PMUL;
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        acc_nxt    = mul_add;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          p_nxt      = mul_add;
          acc_nxt    = '0;
          mcand_nxt  = VAR_BITS'(smag_r);
          mplier_nxt = smag_r;
          cnt_nxt    = CNT_QMUL;
          state_nxt  = S_QMUL;
        end
      end
      S_QMUL: begin
        acc_nxt    = mul_add;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        // a wrapped square sum can leave sum^2 above n*sumsq: clamp to zero
        rad_nxt   = (acc_r <= p_r) ? (p_r - acc_r) : '0;
        rrem_nxt  = '0;
        root_nxt  = '0;
        cnt_nxt   = CNT_ROOT;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        rrem_nxt = root_ge ? (root_sh - root_trial) : root_sh;
        root_nxt = root_q;
        rad_nxt  = rad_r << 2;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dq_nxt    = DIV_BITS'(root_q);
          drem_nxt  = '0;
          cnt_nxt   = CNT_DIV;
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        dq_nxt   = div_q;
        drem_nxt = div_rem;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          sd_nxt    = (|div_q[DIV_BITS-1:VB]) ? '1 : div_q[VB-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_count_nxt = found_r ? n_x[CB_OUT-1:0] : '0;
          out_mean_nxt  = found_r ? mean_r : '0;
          out_min_nxt   = found_r ? min_x[VB-1:0] : '0;
          out_max_nxt   = found_r ? max_x[VB-1:0] : '0;
          out_sd_nxt    = found_r ? sd_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    id_ok_r     <= id_ok_nxt;
    samp_r      <= samp_nxt;
    n_r         <= n_nxt;
    sum_r       <= sum_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    smag_r      <= smag_nxt;
    neg_r       <= neg_nxt;
    found_r     <= found_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    p_r         <= p_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    rad_r       <= rad_nxt;
    rrem_r      <= rrem_nxt;
    root_r      <= root_nxt;
    mean_r      <= mean_nxt;
    sd_r        <= sd_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
    out_mean_r  <= out_mean_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_sd_r    <= out_sd_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.found        = out_found_r;
  assign out_bus.sample_count = out_count_r;
  assign out_bus.mean_value   = out_mean_r;
  assign out_bus.min_value    = out_min_r;
  assign out_bus.max_value    = out_max_r;
  assign out_bus.std_dev      = out_sd_r;

endmodule

FILE: hdl/psrs_checker.sv
`include "per_sensor_running_statistics_unit_assert.svh"

module psrs_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic                                   out_found,
  input logic [psrs_pkg::COUNT_OUT_BITS-1:0]    out_sample_count,
  input logic [psrs_pkg::VALUE_BITS-1:0]        out_mean_value,
  input logic [psrs_pkg::VALUE_BITS-1:0]        out_min_value,
  input logic [psrs_pkg::VALUE_BITS-1:0]        out_max_value,
  input logic [psrs_pkg::VALUE_BITS-1:0]        out_std_dev
);

  `PSRS_ASSERT_ALWAYS(a_no_word_after_reset, clk, !rst_n |=> !out_valid, "result word right after reset")

  `PSRS_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_sample_count) && $stable(out_mean_value) && $stable(out_min_value) && $stable(out_max_value) && $stable(out_std_dev), "stalled result word changed")

  `PSRS_ASSERT_RST(a_one_word_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")

  `PSRS_ASSERT_RST(a_empty_is_zero, clk, rst_n, out_valid && !out_found |-> out_sample_count == '0 && out_mean_value == '0 && out_min_value == '0 && out_max_value == '0 && out_std_dev == '0, "empty report with nonzero fields")

endmodule

bind per_sensor_running_statistics_unit psrs_checker u_psrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_found        (out_bus.found),
  .out_sample_count (out_bus.sample_count),
  .out_mean_value   (out_bus.mean_value),
  .out_min_value    (out_bus.min_value),
  .out_max_value    (out_bus.max_value),
  .out_std_dev      (out_bus.std_dev)
);
